[rtl/rvc_pkg.sv]
// Shared types and constants for the RV32I subset core.
package rvc_pkg;

  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  localparam logic [1:0] ACT_LOAD_MEM = 2'd0;
  localparam logic [1:0] ACT_EXECUTE  = 2'd1;
  localparam logic [1:0] ACT_READ_REG = 2'd2;
  localparam logic [1:0] ACT_NONE     = 2'd3;

  localparam logic [6:0] OPC_HALT   = 7'h00;
  localparam logic [6:0] OPC_RTYPE  = 7'h33;
  localparam logic [6:0] OPC_ITYPE  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LUI    = 7'h37;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SRA  = 3'd5;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_W    = 3'd2;
  localparam logic [2:0] F3_H    = 3'd1;
  localparam logic [2:0] F3_BU   = 3'd4;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;     // input item accepted this cycle
    logic decode;   // fetched word is on the memory read port
    logic exec;     // operands are on the register file read ports
    logic load_wb;  // load data is on the memory read port
    logic rd_cap;   // register read data is on the read port
    logic finish;   // result moves into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic halted;
    logic opc_zero;
    logic is_load;
  } stat_t;

endpackage

[rtl/rvc_ram.sv]
// Generic single-port RAM with registered read data.
module rvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/rvc_ctrl.sv]
// Controller state machine that sequences each item through the datapath.
module rvc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     action_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rvc_pkg::stat_t stat_i,
  output rvc_pkg::cmd_t  cmd_o
);
  import rvc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_EXEC, S_LOAD_WB, S_READ_REG, S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   take;
  logic   finish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign take        = in_valid_i && in_ready_o;
  assign finish      = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Commands decoded from the current state.
  always_comb begin
    cmd_o         = '0;
    cmd_o.take    = take;
    cmd_o.decode  = (state_q == S_DECODE);
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.load_wb = (state_q == S_LOAD_WB);
    cmd_o.rd_cap  = (state_q == S_READ_REG);
    cmd_o.finish  = finish;
  end

  // Output valid drops when the result is taken and rises when a new one is finished.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            if (action_i == ACT_EXECUTE && !stat_i.halted) begin
              state_q <= S_DECODE;
            end else if (action_i == ACT_READ_REG) begin
              state_q <= S_READ_REG;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DECODE: begin
          state_q <= stat_i.opc_zero ? S_DONE : S_EXEC;
        end
        S_EXEC: begin
          state_q <= stat_i.is_load ? S_LOAD_WB : S_DONE;
        end
        S_LOAD_WB:  state_q <= S_DONE;
        S_READ_REG: state_q <= S_DONE;
        S_DONE: begin
          if (finish) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> !in_ready_o) else $error("ready stayed high after an item was taken");
  a_out_needs_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(finish)) else $error("result shown without finish");
  a_finish_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> !in_ready_o) else $error("finish outside the done state");
`endif

endmodule

[rtl/rvc_datapath.sv]
// Datapath: PC, halt flag, register file, byte-lane memory, ALU and result registers.
module rvc_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rvc_pkg::cmd_t      cmd_i,
  output rvc_pkg::stat_t     stat_o,
  input  logic [1:0]         action_i,
  input  logic [9:0]         word_address_i,
  input  logic [31:0]        load_word_i,
  input  logic [4:0]         reg_index_i,
  output logic [31:0]        pc_o,
  output logic               halted_o,
  output logic               wrote_register_o,
  output logic [4:0]         dest_register_o,
  output logic signed [31:0] written_value_o,
  output logic               wrote_memory_o,
  output logic signed [31:0] read_value_o
);
  import rvc_pkg::*;

  logic [31:0] pc_q, ins_q;
  logic        halt_q;
  logic [1:0]  off_q;
  logic [2:0]  ld_f3_q;
  logic [4:0]  ra_q, rb_q;
  logic [31:0] rf_vld_q;
  logic        res_wr_q, res_wmem_q;
  logic [4:0]  res_rd_q;
  logic [31:0] res_val_q, res_rval_q;

  logic        mem_fill;
  logic [31:0] acc_addr;
  logic [7:0]  lane_rdata [4];
  logic [31:0] mword;
  logic [31:0] rfa_rdata, rfb_rdata, a, b;
  logic        rf_we;
  logic [4:0]  rf_addr_a, rf_addr_b;
  logic [31:0] rf_wdata;

  // Instruction fields, immediates and ALU.
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] imm_i, imm_s, imm_b, ea, alu_res, pc_next;
  logic        alu_wr, st_en;
  logic [2:0]  st_bytes;

  assign opc   = ins_q[6:0];
  assign rd    = ins_q[11:7];
  assign f3    = ins_q[14:12];
  assign f7    = ins_q[31:25];
  assign imm_i = {{20{ins_q[31]}}, ins_q[31:20]};
  assign imm_s = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
  assign imm_b = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
  assign ea    = a + ((opc == OPC_STORE) ? imm_s : imm_i);

  always_comb begin
    alu_res  = '0;
    alu_wr   = 1'b0;
    pc_next  = pc_q + 32'd4;
    st_en    = 1'b0;
    st_bytes = 3'd4;
    unique case (opc)
      OPC_RTYPE: begin
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          alu_res = a + b;
          alu_wr  = 1'b1;
        end else if (f3 == F3_ADD && f7 == F7_ALT) begin
          alu_res = a - b;
          alu_wr  = 1'b1;
        end else if (f3 == F3_SRA && f7 == F7_ALT) begin
          alu_res = 32'($signed(a) >>> b[4:0]);
          alu_wr  = 1'b1;
        end else if (f3 == F3_AND && f7 == F7_BASE) begin
          alu_res = a & b;
          alu_wr  = 1'b1;
        end
      end
      OPC_ITYPE: begin
        if (f3 == F3_ADD) begin
          alu_res = a + imm_i;
          alu_wr  = 1'b1;
        end else if (f3 == F3_OR) begin
          alu_res = a | imm_i;
          alu_wr  = 1'b1;
        end else if (f3 == F3_SLTU) begin
          alu_res = {31'd0, a < imm_i};
          alu_wr  = 1'b1;
        end
      end
      OPC_STORE: begin
        st_en    = (f3 == F3_W) || (f3 == F3_H);
        st_bytes = (f3 == F3_W) ? 3'd4 : 3'd2;
      end
      OPC_BRANCH: begin
        if (a != b) begin
          pc_next = pc_q + imm_b;
        end
      end
      OPC_JALR: begin
        alu_res = pc_q + 32'd4;
        alu_wr  = 1'b1;
        pc_next = (a + imm_i) & ~32'd1;
      end
      OPC_LUI: begin
        alu_res = {ins_q[31:12], 12'd0};
        alu_wr  = 1'b1;
      end
      default: ;
    endcase
  end

  // Byte-lane memory: lane k holds bytes whose address is k mod 4, so an
  // unaligned word touches each lane once and needs a single access.
  assign mem_fill = cmd_i.take && (action_i == ACT_LOAD_MEM);
  assign acc_addr = cmd_i.exec ? ea : pc_q;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [1:0]        idx;
    logic [MEM_AW-1:0] row;
    logic              we;
    logic [7:0]        wdata;

    assign idx   = 2'(k) - acc_addr[1:0];
    assign row   = acc_addr[MEM_AW+1:2] + MEM_AW'(2'(k) < acc_addr[1:0]);
    assign we    = mem_fill || (cmd_i.exec && st_en && (3'(idx) < st_bytes));
    assign wdata = mem_fill ? load_word_i[8*k +: 8] : b[8*idx +: 8];

    rvc_ram #(.WIDTH(8), .DEPTH(MEM_WORDS)) u_lane (
      .clk_i   (clk_i),
      .we_i    (we),
      .addr_i  (mem_fill ? MEM_AW'(word_address_i) : row),
      .wdata_i (wdata),
      .rdata_o (lane_rdata[k])
    );
  end

  // Reassemble the accessed word from the lanes.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mword[8*i +: 8] = lane_rdata[2'(off_q + 2'(i))];
    end
  end

  // Register file: two copies for two read ports, valid bits give zero reset.
  assign rf_we     = ((cmd_i.exec && alu_wr && opc != OPC_LOAD) || cmd_i.load_wb)
                     && (rd != 5'd0);
  assign rf_wdata  = cmd_i.load_wb ? (ld_f3_q == F3_W  ? mword :
                                      ld_f3_q == F3_BU ? {24'd0, mword[7:0]} : 32'd0)
                                   : alu_res;
  assign rf_addr_a = rf_we ? rd : (cmd_i.take ? reg_index_i : mword[19:15]);
  assign rf_addr_b = rf_we ? rd : mword[24:20];

  rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i(clk_i), .we_i(rf_we), .addr_i(rf_addr_a), .wdata_i(rf_wdata), .rdata_o(rfa_rdata)
  );
  rvc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i(clk_i), .we_i(rf_we), .addr_i(rf_addr_b), .wdata_i(rf_wdata), .rdata_o(rfb_rdata)
  );

  assign a = (rf_vld_q[ra_q] && ra_q != 5'd0) ? rfa_rdata : 32'd0;
  assign b = (rf_vld_q[rb_q] && rb_q != 5'd0) ? rfb_rdata : 32'd0;

  assign stat_o.halted   = halt_q;
  assign stat_o.opc_zero = (mword[6:0] == OPC_HALT);
  assign stat_o.is_load  = (opc == OPC_LOAD);

  // Control state: PC, halt and register valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      halt_q   <= 1'b0;
      rf_vld_q <= '0;
    end else begin
      if (cmd_i.decode && mword[6:0] == OPC_HALT) begin
        halt_q <= 1'b1;
      end
      if (cmd_i.exec) begin
        pc_q <= pc_next;
      end
      if (rf_we) begin
        rf_vld_q[rd] <= 1'b1;
      end
    end
  end

  // Payload registers of the item in flight.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take || cmd_i.exec) begin
      off_q <= acc_addr[1:0];
    end
    if (cmd_i.take) begin
      ra_q       <= reg_index_i;
      res_wr_q   <= 1'b0;
      res_wmem_q <= 1'b0;
      res_rd_q   <= '0;
      res_val_q  <= '0;
      res_rval_q <= '0;
    end
    if (cmd_i.decode) begin
      ins_q <= mword;
      ra_q  <= mword[19:15];
      rb_q  <= mword[24:20];
    end
    if (cmd_i.exec) begin
      ld_f3_q    <= f3;
      res_wmem_q <= st_en;
    end
    if (rf_we) begin
      res_wr_q  <= 1'b1;
      res_rd_q  <= rd;
      res_val_q <= rf_wdata;
    end
    if (cmd_i.rd_cap) begin
      res_rval_q <= a;
    end
    if (cmd_i.finish) begin
      pc_o             <= pc_q;
      halted_o         <= halt_q;
      wrote_register_o <= res_wr_q;
      dest_register_o  <= res_rd_q;
      written_value_o  <= res_val_q;
      wrote_memory_o   <= res_wmem_q;
      read_value_o     <= res_rval_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pc_q[0]) else $error("program counter became odd");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(halt_q) |-> halt_q) else $error("halt flag cleared");
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rd != 5'd0) else $error("write to register zero");
`endif

endmodule

[rtl/rv32i_subset_single_cycle_core.sv]
// Top level of the RV32I subset core: controller plus datapath.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i/in_ready_o   action, word_address, load_word, reg_index
//   out      source     out_valid_o/out_ready_i pc, halted, wrote_register, dest_register,
//                                               written_value, wrote_memory, read_value
//
// Memory load, execute on a halted core and idle items go straight to the done state; register
// reads pass through the read state, the fetch of a zero-opcode word through decode. An instruction
// steps through fetch, register read and execute, a load instruction additionally through a
// second access of the single-port byte-lane memory for load data.
// Reset clears PC, halt flag and register valid bits at once; no clearing pass.
// A new item is taken while the previous result waits in the output register;
// the core stalls in its final step only until that register is free.
module rv32i_subset_single_cycle_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [9:0]         word_address_i,
  input  logic [31:0]        load_word_i,
  input  logic [4:0]         reg_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        pc_o,
  output logic               halted_o,
  output logic               wrote_register_o,
  output logic [4:0]         dest_register_o,
  output logic signed [31:0] written_value_o,
  output logic               wrote_memory_o,
  output logic signed [31:0] read_value_o
);
  import rvc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rvc_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .action_i         (action_i),
    .word_address_i   (word_address_i),
    .load_word_i      (load_word_i),
    .reg_index_i      (reg_index_i),
    .pc_o             (pc_o),
    .halted_o         (halted_o),
    .wrote_register_o (wrote_register_o),
    .dest_register_o  (dest_register_o),
    .written_value_o  (written_value_o),
    .wrote_memory_o   (wrote_memory_o),
    .read_value_o     (read_value_o)
  );

endmodule
